>>> sv/rmu_pkg.sv
// Package: shared types and codes for the record marker unblocker.
package rmu_pkg;

   // Framing phase of the byte stream
   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_PAY   = 2'd1,
      PH_TRAIL = 2'd2,
      PH_HALT  = 2'd3
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_END      = 2'd1,
      ST_MISMATCH = 2'd2,
      ST_TRUNC    = 2'd3
   } status_type;

   // Marker widths in bytes
   localparam logic [3:0] MARKER_BYTES_SHORT = 4'd4;
   localparam logic [3:0] MARKER_BYTES_LONG  = 4'd8;

   // Input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       record_last;
      status_type status;
   } rsp_word_type;

   // Step result handed from the core to the output register
   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_out_type;

endpackage

>>> sv/rmu_core.sv
// Module: framing state and single-pass per-word step logic.
module rmu_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rmu_pkg::req_word_type word,
   input  logic                  marker_size_mode,
   output rmu_pkg::step_out_type step
);

   rmu_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         count_ff, count_in;
   logic [31:0]        assembly_ff, assembly_in;
   logic [30:0]        length_ff, length_in;
   logic [30:0]        remaining_ff, remaining_in;

   // Marker byte assembly
   logic [3:0]  size;
   logic [3:0]  count_next;
   logic [31:0] marker_value;
   logic        marker_done;

   always_comb begin
      size         = marker_size_mode ? rmu_pkg::MARKER_BYTES_LONG
                                      : rmu_pkg::MARKER_BYTES_SHORT;
      marker_value = assembly_ff;
      case (count_ff)
         3'd0: marker_value[7:0]   = word.data_byte;
         3'd1: marker_value[15:8]  = assembly_ff[15:8] | word.data_byte;
         3'd2: marker_value[23:16] = assembly_ff[23:16] | word.data_byte;
         3'd3: marker_value[31:24] = assembly_ff[31:24] | word.data_byte;
         default: marker_value = assembly_ff;
      endcase
      // lane 0 is always empty at count zero; keep the OR form for clarity
      if (count_ff == 3'd0) begin
         marker_value[7:0] = assembly_ff[7:0] | word.data_byte;
      end
      count_next  = {1'b0, count_ff} + 4'd1;
      marker_done = (count_next >= size);
   end

   // Next state and result
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      assembly_in  = assembly_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      step.emit             = 1'b0;
      step.word.out_byte    = 8'd0;
      step.word.record_last = 1'b0;
      step.word.status      = rmu_pkg::ST_DATA;

      if (phase_ff == rmu_pkg::PH_HALT) begin
         step.emit = 1'b0;
      end else if (word.end_of_stream) begin
         step.emit = 1'b1;
         phase_in  = rmu_pkg::PH_HALT;
         if (phase_ff == rmu_pkg::PH_LEAD && count_ff == 3'd0) begin
            step.word.status = rmu_pkg::ST_END;
         end else begin
            step.word.status = rmu_pkg::ST_TRUNC;
         end
      end else begin
         case (phase_ff)
            rmu_pkg::PH_LEAD: begin
               if (!marker_done) begin
                  count_in    = count_next[2:0];
                  assembly_in = marker_value;
               end else begin
                  count_in    = 3'd0;
                  assembly_in = 32'd0;
                  if (marker_value == 32'd0 || marker_value[31]) begin
                     step.emit        = 1'b1;
                     step.word.status = rmu_pkg::ST_END;
                     phase_in         = rmu_pkg::PH_HALT;
                  end else begin
                     length_in    = marker_value[30:0];
                     remaining_in = marker_value[30:0];
                     phase_in     = rmu_pkg::PH_PAY;
                  end
               end
            end
            rmu_pkg::PH_PAY: begin
               step.emit          = 1'b1;
               step.word.out_byte = word.data_byte;
               if (remaining_ff <= 31'd1) begin
                  step.word.record_last = 1'b1;
                  remaining_in = 31'd0;
                  phase_in     = rmu_pkg::PH_TRAIL;
                  count_in     = 3'd0;
                  assembly_in  = 32'd0;
               end else begin
                  remaining_in = remaining_ff - 31'd1;
               end
            end
            rmu_pkg::PH_TRAIL: begin
               if (!marker_done) begin
                  count_in    = count_next[2:0];
                  assembly_in = marker_value;
               end else begin
                  count_in    = 3'd0;
                  assembly_in = 32'd0;
                  if (marker_value != {1'b0, length_ff}) begin
                     step.emit        = 1'b1;
                     step.word.status = rmu_pkg::ST_MISMATCH;
                     phase_in         = rmu_pkg::PH_HALT;
                  end else begin
                     phase_in = rmu_pkg::PH_LEAD;
                  end
               end
            end
            default: begin
               step.emit = 1'b0;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rmu_pkg::PH_LEAD;
         count_ff     <= 3'd0;
         assembly_ff  <= 32'd0;
         length_ff    <= 31'd0;
         remaining_ff <= 31'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         assembly_ff  <= assembly_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
      end
   end

   // Halted block never produces a result
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rmu_pkg::PH_HALT |-> !step.emit)
      else $error("result produced while halted");

   // Any non-data result halts the block
   a_end_halts: assert property (@(posedge clock) disable iff (reset)
      fire && step.emit && step.word.status != rmu_pkg::ST_DATA
      |=> phase_ff == rmu_pkg::PH_HALT)
      else $error("terminal status without halt");

   // Payload phase always has bytes left
   a_pay_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rmu_pkg::PH_PAY |-> remaining_ff != 31'd0)
      else $error("payload phase with zero bytes remaining");

endmodule

>>> sv/record_marker_unblocker_unit.sv
// Module: top level of the record marker unblocker.
//
// Strips record framing (leading length marker, payload, trailing marker)
// from a byte stream. Input words arrive on req_valid/req_word and are taken
// when req_stall is low; result words leave on rsp_valid/rsp_word and are
// taken when rsp_stall is low. A word with end_of_stream set carries no byte.
// Marker bytes produce no result; each payload byte produces one, with
// record_last on the final byte. Clean end, marker mismatch and truncation
// each produce one status word, after which the block stays halted.
// Each result passes through the input register, then the result register.
// Throughput: one word per cycle while rsp_stall is low, set by the
// single-pass step logic between those two registers.
// csr_data selects the marker width (0: 4 bytes, 1: 8 bytes); it is written
// when csr_valid and csr_ready are high, and only while no word is held.
// Synchronous reset clears the framing state, the width select and both
// register stages. When rsp_stall holds a result, the held input word waits
// and req_stall rises until the result register frees.
module record_marker_unblocker_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rmu_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rmu_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   logic                  s1_valid_ff, s1_valid_in;
   rmu_pkg::req_word_type s1_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rmu_pkg::rsp_word_type rsp_word_ff;
   logic                  mode_ff;
   logic                  advance;
   logic                  accept;
   rmu_pkg::step_out_type step;

   // Handshake control
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !s1_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = step.emit;
      end
   end

   rmu_core u_core (
      .clock            (clock),
      .reset            (reset),
      .fire             (advance),
      .word             (s1_word_ff),
      .marker_size_mode (mode_ff),
      .step             (step)
   );

   // Input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
      if (advance && step.emit) begin
         rsp_word_ff <= step.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Status words carry no byte and no last flag
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != rmu_pkg::ST_DATA
      |-> rsp_word_ff.out_byte == 8'd0 && !rsp_word_ff.record_last)
      else $error("status word with payload fields set");

   // A held input word moves on once the result register frees
   a_no_lost_word: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |-> !req_stall)
      else $error("stall raised with result register empty");

   // Width select only changes with no word in flight
   a_mode_idle: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> $stable(mode_ff))
      else $error("marker width changed while a word is held");

endmodule
